### src/sbr_pkg.sv
// Shared types, constants and helper functions of the bell resonator synthesiser.
package sbr_pkg;

    // Fixed sizes.
    localparam int NUM_RES        = 5;
    localparam int COS_TABLE_BITS = 10;
    localparam int OUT_WIDTH      = 24;
    localparam int TDATA_W        = ((OUT_WIDTH + 7) / 8) * 8;
    localparam int PH_SHIFT       = 16 - COS_TABLE_BITS;

    // Arithmetic constants.
    localparam logic [22:0] ENERGY_ONE      = 23'h400000;
    localparam logic [12:0] TENTH_Q16       = 13'd6554;
    localparam logic [15:0] SOUND_DECAY_Q16 = 16'd63570;
    localparam logic [16:0] TWO_R_Q16       = 17'd129761;
    localparam logic [22:0] R_SQ_Q22        = 23'd4110837;
    localparam logic [30:0] LCG_MUL         = 31'd1103515245;
    localparam logic [31:0] LCG_ADD         = 32'd12345;
    localparam logic [31:0] PRNG_SEED       = 32'd12345;
    localparam logic [28:0] POLY_A          = 29'd331168970;
    localparam logic [28:0] POLY_B          = 29'd68093890;
    localparam logic [28:0] POLY_C          = 29'd5600498;
    localparam logic [28:0] POLY_D          = 29'd246762;
    localparam logic [15:0] PH_MASK         = ~((16'd1 << PH_SHIFT) - 16'd1);
    localparam logic signed [32:0] OUT_MAX  = (33'sd1 <<< (OUT_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] OUT_MIN  = -(33'sd1 <<< (OUT_WIDTH - 1));

    // Register indexes of the configuration port.
    localparam logic [3:0] CFG_THRESHOLD = 4'd0;
    localparam logic [3:0] CFG_GAIN      = 4'd1;
    localparam logic [3:0] CFG_DECAY     = 4'd2;
    localparam logic [3:0] CFG_STEP0     = 4'd3;
    localparam logic [3:0] CFG_STEP1     = 4'd4;
    localparam logic [3:0] CFG_STEP2     = 4'd5;
    localparam logic [3:0] CFG_STEP3     = 4'd6;
    localparam logic [3:0] CFG_STEP4     = 4'd7;

    // Datapath operations, each one multiply followed by a write-back.
    typedef enum logic [4:0] {
        OP_SHAKE, OP_DECAY, OP_DRAW_EV, OP_GAIN, OP_JDRAW, OP_JIT1, OP_JIT2,
        OP_SQ, OP_P1, OP_P2, OP_P3, OP_P4, OP_COEF, OP_NDRAW, OP_XMUL,
        OP_SDECAY, OP_BR, OP_CP, OP_RP
    } op_t;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_WB, ST_OUT} state_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] k;
        logic       mul;
        logic       wb;
        logic       init;
        logic       take;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic event_hit;
        logic out_busy;
    } status_t;

    // Centre phase steps after reset.
    function automatic logic [14:0] reset_step(input logic [2:0] k);
        logic [14:0] v;
        unique case (k)
            3'd0:    v = 15'd3715;
            3'd1:    v = 15'd7876;
            3'd2:    v = 15'd9660;
            3'd3:    v = 15'd12334;
            default: v = 15'd14564;
        endcase
        return v;
    endfunction

    // Excitation gain of each resonator branch, Q16.
    function automatic logic [16:0] branch_gain(input logic [2:0] k);
        logic [16:0] v;
        unique case (k)
            3'd0, 3'd1, 3'd2: v = 17'd65536;
            3'd3:             v = 17'd32768;
            default:          v = 17'd19661;
        endcase
        return v;
    endfunction

    // Jitter depth, Q16: wide for the first resonator, narrow for the rest.
    function automatic logic [11:0] jit_gain(input logic [2:0] k);
        return (k == 3'd0) ? 12'd3277 : 12'd1966;
    endfunction

    // Saturate to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sh07FFFFFFF)       r = 32'sh7FFFFFFF;
        else if (v < -36'sh080000000) r = 32'sh80000000;
        else                          r = v[31:0];
        return r;
    endfunction

endpackage

### src/sbr_ctrl.sv
// Sequencer that steps the shared multiplier datapath through one sample tick.
module sbr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sbr_pkg::status_t status,
    output sbr_pkg::cmd_t    cmd
);

    sbr_pkg::state_t state_reg, state_next;
    sbr_pkg::op_t    op_reg, op_next;
    logic [2:0]      k_reg, k_next;
    logic            init_reg, init_next;

    // After reset the coefficient pass runs first, starting at the phase step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbr_pkg::ST_MUL;
            op_reg    <= sbr_pkg::OP_JIT2;
            k_reg     <= 3'd0;
            init_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
            init_reg  <= init_next;
        end
    end

    // Next state and next operation.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        k_next     = k_reg;
        init_next  = init_reg;
        unique case (state_reg)
            sbr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sbr_pkg::ST_MUL;
                    op_next    = sbr_pkg::OP_SHAKE;
                    k_next     = 3'd0;
                end
            end
            sbr_pkg::ST_MUL: state_next = sbr_pkg::ST_WB;
            sbr_pkg::ST_WB: begin
                state_next = sbr_pkg::ST_MUL;
                unique case (op_reg)
                    sbr_pkg::OP_SHAKE:  op_next = sbr_pkg::OP_DECAY;
                    sbr_pkg::OP_DECAY:  op_next = sbr_pkg::OP_DRAW_EV;
                    sbr_pkg::OP_DRAW_EV: begin
                        op_next = status.event_hit ? sbr_pkg::OP_GAIN : sbr_pkg::OP_NDRAW;
                    end
                    sbr_pkg::OP_GAIN: begin
                        op_next = sbr_pkg::OP_JDRAW;
                        k_next  = 3'd0;
                    end
                    sbr_pkg::OP_JDRAW:  op_next = sbr_pkg::OP_JIT1;
                    sbr_pkg::OP_JIT1:   op_next = sbr_pkg::OP_JIT2;
                    sbr_pkg::OP_JIT2:   op_next = sbr_pkg::OP_SQ;
                    sbr_pkg::OP_SQ:     op_next = sbr_pkg::OP_P1;
                    sbr_pkg::OP_P1:     op_next = sbr_pkg::OP_P2;
                    sbr_pkg::OP_P2:     op_next = sbr_pkg::OP_P3;
                    sbr_pkg::OP_P3:     op_next = sbr_pkg::OP_P4;
                    sbr_pkg::OP_P4:     op_next = sbr_pkg::OP_COEF;
                    sbr_pkg::OP_COEF: begin
                        if (k_reg == 3'(sbr_pkg::NUM_RES - 1)) begin
                            k_next = 3'd0;
                            if (init_reg) begin
                                state_next = sbr_pkg::ST_IDLE;
                                init_next  = 1'b0;
                            end else begin
                                op_next = sbr_pkg::OP_NDRAW;
                            end
                        end else begin
                            k_next  = k_reg + 3'd1;
                            op_next = init_reg ? sbr_pkg::OP_JIT2 : sbr_pkg::OP_JDRAW;
                        end
                    end
                    sbr_pkg::OP_NDRAW:  op_next = sbr_pkg::OP_XMUL;
                    sbr_pkg::OP_XMUL:   op_next = sbr_pkg::OP_SDECAY;
                    sbr_pkg::OP_SDECAY: begin
                        op_next = sbr_pkg::OP_BR;
                        k_next  = 3'd0;
                    end
                    sbr_pkg::OP_BR:     op_next = sbr_pkg::OP_CP;
                    sbr_pkg::OP_CP:     op_next = sbr_pkg::OP_RP;
                    sbr_pkg::OP_RP: begin
                        if (k_reg == 3'(sbr_pkg::NUM_RES - 1)) begin
                            state_next = sbr_pkg::ST_OUT;
                        end else begin
                            k_next  = k_reg + 3'd1;
                            op_next = sbr_pkg::OP_BR;
                        end
                    end
                    default: state_next = sbr_pkg::ST_IDLE;
                endcase
            end
            sbr_pkg::ST_OUT: begin
                if (!status.out_busy) state_next = sbr_pkg::ST_IDLE;
            end
            default: state_next = sbr_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd.op       = op_reg;
        cmd.k        = k_reg;
        cmd.init     = init_reg;
        cmd.mul      = 1'b0;
        cmd.wb       = 1'b0;
        cmd.take     = 1'b0;
        cmd.load_out = 1'b0;
        s_tready     = 1'b0;
        unique case (state_reg)
            sbr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            sbr_pkg::ST_MUL: cmd.mul = 1'b1;
            sbr_pkg::ST_WB:  cmd.wb  = 1'b1;
            sbr_pkg::ST_OUT: cmd.load_out = !status.out_busy;
            default: ;
        endcase
    end

endmodule

### src/sbr_dp.sv
// Datapath: configuration, state registers, shared multiplier and output register.
module sbr_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  sbr_pkg::cmd_t               cmd,
    output sbr_pkg::status_t            status,
    input  logic [15:0]                 shake_in,
    input  logic                        cfg_wr_en,
    input  logic [3:0]                  cfg_index,
    input  logic [15:0]                 cfg_wr_data,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sbr_pkg::TDATA_W-1:0] m_tdata
);

    // Configuration registers.
    logic [10:0] thr_reg;
    logic [15:0] gain_reg;
    logic [15:0] decay_reg;
    logic [14:0] step_reg [sbr_pkg::NUM_RES];

    // Tick state.
    logic [15:0]        shake_reg;
    logic [22:0]        energy_reg, energy_next;
    logic [31:0]        level_reg, level_next;
    logic [31:0]        prng_reg, prng_next;
    logic [14:0]        draw_reg, draw_next;
    logic signed [30:0] jp_reg, jp_next;
    logic [14:0]        t_reg, t_next;
    logic               neg_reg, neg_next;
    logic [28:0]        u2_reg, u2_next;
    logic [28:0]        w_reg, w_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [35:0] acc_reg, acc_next;
    logic signed [34:0] sum_reg, sum_next;
    logic signed [23:0] coeff_reg [sbr_pkg::NUM_RES];
    logic signed [23:0] coeff_next [sbr_pkg::NUM_RES];
    logic signed [31:0] p1_reg [sbr_pkg::NUM_RES];
    logic signed [31:0] p1_next [sbr_pkg::NUM_RES];
    logic signed [31:0] p2_reg [sbr_pkg::NUM_RES];
    logic signed [31:0] p2_next [sbr_pkg::NUM_RES];
    logic signed [31:0] sd0_reg, sd0_next, sd1_reg, sd1_next;
    logic [sbr_pkg::OUT_WIDTH-1:0] out_reg, out_next;
    logic               outv_reg;

    // Shared multiplier.
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    // Write-back temporaries.
    logic signed [15:0] noise;
    logic [31:0]        lcg_next;
    logic [28:0]        inc_rnd;
    logic [23:0]        e_sum;
    logic [32:0]        sl_sum;
    logic signed [65:0] shr16, shr22, shr30;
    logic [14:0]        base_step;
    logic signed [16:0] jit, ph_sum;
    logic [15:0]        ph_t;
    logic [16:0]        fold1;
    logic signed [30:0] r_val;
    logic [23:0]        mag;
    logic signed [35:0] y_val;
    logic signed [31:0] y_sat, s_sat;
    logic signed [32:0] diff;

    function automatic logic signed [32:0] zx(input logic [31:0] v);
        return $signed({1'b0, v});
    endfunction

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= 11'd32;
            gain_reg  <= 16'd1024;
            decay_reg <= 16'd65497;
            for (int i = 0; i < sbr_pkg::NUM_RES; i++) begin
                step_reg[i] <= sbr_pkg::reset_step(3'(i));
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sbr_pkg::CFG_THRESHOLD: thr_reg     <= cfg_wr_data[10:0];
                sbr_pkg::CFG_GAIN:      gain_reg    <= cfg_wr_data;
                sbr_pkg::CFG_DECAY:     decay_reg   <= cfg_wr_data;
                sbr_pkg::CFG_STEP0:     step_reg[0] <= cfg_wr_data[14:0];
                sbr_pkg::CFG_STEP1:     step_reg[1] <= cfg_wr_data[14:0];
                sbr_pkg::CFG_STEP2:     step_reg[2] <= cfg_wr_data[14:0];
                sbr_pkg::CFG_STEP3:     step_reg[3] <= cfg_wr_data[14:0];
                sbr_pkg::CFG_STEP4:     step_reg[4] <= cfg_wr_data[14:0];
                default: ;
            endcase
        end
    end

    assign noise = $signed({1'b0, draw_reg}) - 16'sd16384;

    // Multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            sbr_pkg::OP_SHAKE: begin
                mul_a = zx(32'(shake_reg));
                mul_b = zx(32'(sbr_pkg::TENTH_Q16));
            end
            sbr_pkg::OP_DECAY: begin
                mul_a = zx(32'(energy_reg));
                mul_b = zx(32'(decay_reg));
            end
            sbr_pkg::OP_DRAW_EV, sbr_pkg::OP_JDRAW, sbr_pkg::OP_NDRAW: begin
                mul_a = zx(prng_reg);
                mul_b = zx(32'(sbr_pkg::LCG_MUL));
            end
            sbr_pkg::OP_GAIN: begin
                mul_a = zx(32'(gain_reg));
                mul_b = zx(32'(energy_reg));
            end
            sbr_pkg::OP_JIT1: begin
                mul_a = zx(32'(step_reg[cmd.k]));
                mul_b = 33'(noise);
            end
            sbr_pkg::OP_JIT2: begin
                mul_a = 33'(jp_reg);
                mul_b = zx(32'(sbr_pkg::jit_gain(cmd.k)));
            end
            sbr_pkg::OP_SQ: begin
                mul_a = zx(32'(t_reg));
                mul_b = zx(32'(t_reg));
            end
            sbr_pkg::OP_P1: begin
                mul_a = zx(32'(sbr_pkg::POLY_D));
                mul_b = zx(32'(u2_reg));
            end
            sbr_pkg::OP_P2: begin
                mul_a = zx(32'(sbr_pkg::POLY_C) - 32'(w_reg));
                mul_b = zx(32'(u2_reg));
            end
            sbr_pkg::OP_P3: begin
                mul_a = zx(32'(sbr_pkg::POLY_B) - 32'(w_reg));
                mul_b = zx(32'(u2_reg));
            end
            sbr_pkg::OP_P4: begin
                mul_a = zx(32'(sbr_pkg::POLY_A) - 32'(w_reg));
                mul_b = zx(32'(u2_reg));
            end
            sbr_pkg::OP_COEF: begin
                mul_a = zx(32'(w_reg));
                mul_b = zx(32'(sbr_pkg::TWO_R_Q16));
            end
            sbr_pkg::OP_XMUL: begin
                mul_a = zx(level_reg);
                mul_b = 33'(noise);
            end
            sbr_pkg::OP_SDECAY: begin
                mul_a = zx(level_reg);
                mul_b = zx(32'(sbr_pkg::SOUND_DECAY_Q16));
            end
            sbr_pkg::OP_BR: begin
                mul_a = 33'(x_reg);
                mul_b = zx(32'(sbr_pkg::branch_gain(cmd.k)));
            end
            sbr_pkg::OP_CP: begin
                mul_a = 33'(coeff_reg[cmd.k]);
                mul_b = 33'(p1_reg[cmd.k]);
            end
            sbr_pkg::OP_RP: begin
                mul_a = zx(32'(sbr_pkg::R_SQ_Q22));
                mul_b = 33'(p2_reg[cmd.k]);
            end
            default: ;
        endcase
    end

    // Product register.
    always_ff @(posedge aclk) begin
        if (cmd.mul) prod_reg <= mul_a * mul_b;
    end

    // Shared write-back arithmetic on the product.
    assign shr16    = prod_reg >>> 16;
    assign shr22    = prod_reg >>> 22;
    assign shr30    = prod_reg >>> 30;
    assign lcg_next = prod_reg[31:0] + sbr_pkg::LCG_ADD;
    assign inc_rnd  = prod_reg[28:0] + 29'd512;
    assign e_sum    = {1'b0, energy_reg} + 24'(inc_rnd[28:10]);
    assign sl_sum   = {1'b0, level_reg} + 33'(prod_reg[37:12]);
    assign base_step = cmd.init ? sbr_pkg::reset_step(cmd.k) : step_reg[cmd.k];
    assign jit      = cmd.init ? 17'sd0 : shr30[16:0];
    assign ph_sum   = $signed({2'b00, base_step}) + jit;
    assign ph_t     = ph_sum[15:0] & sbr_pkg::PH_MASK;
    assign fold1    = ph_t[15] ? (17'h10000 - {1'b0, ph_t}) : {1'b0, ph_t};
    assign r_val    = 31'sh10000000 - $signed({1'b0, prod_reg[57:28]});
    assign mag      = prod_reg[45:22];
    assign y_val    = acc_reg - shr22[35:0];
    assign y_sat    = sbr_pkg::sat32(y_val);
    assign s_sat    = sbr_pkg::sat32(36'(sum_reg));
    assign diff     = 33'(sd1_reg) - 33'(s_sat);

    // Event check on a fresh draw.
    assign status.event_hit = {1'b0, lcg_next[30:21]} < thr_reg;
    assign status.out_busy  = outv_reg & ~m_tready;

    // Next values of the state for the current write-back.
    always_comb begin
        energy_next = energy_reg;
        level_next  = level_reg;
        prng_next   = prng_reg;
        draw_next   = draw_reg;
        jp_next     = jp_reg;
        t_next      = t_reg;
        neg_next    = neg_reg;
        u2_next     = u2_reg;
        w_next      = w_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        sum_next    = sum_reg;
        coeff_next  = coeff_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        sd0_next    = sd0_reg;
        sd1_next    = sd1_reg;
        out_next    = out_reg;
        if (cmd.wb) begin
            unique case (cmd.op)
                sbr_pkg::OP_SHAKE: begin
                    if (shake_reg != 16'd0) begin
                        energy_next = (e_sum > 24'(sbr_pkg::ENERGY_ONE)) ?
                                      sbr_pkg::ENERGY_ONE : e_sum[22:0];
                    end
                end
                sbr_pkg::OP_DECAY: energy_next = prod_reg[38:16];
                sbr_pkg::OP_DRAW_EV, sbr_pkg::OP_JDRAW, sbr_pkg::OP_NDRAW: begin
                    prng_next = lcg_next;
                    draw_next = lcg_next[30:16];
                end
                sbr_pkg::OP_GAIN: level_next = sl_sum[32] ? 32'hFFFFFFFF : sl_sum[31:0];
                sbr_pkg::OP_JIT1: jp_next = prod_reg[30:0];
                sbr_pkg::OP_JIT2: begin
                    // Fold the phase into the first quarter turn.
                    if (fold1 > 17'd16384) begin
                        neg_next = 1'b1;
                        t_next   = 15'(17'd32768 - fold1);
                    end else begin
                        neg_next = 1'b0;
                        t_next   = fold1[14:0];
                    end
                end
                sbr_pkg::OP_SQ: u2_next = prod_reg[28:0];
                sbr_pkg::OP_P1, sbr_pkg::OP_P2, sbr_pkg::OP_P3: w_next = prod_reg[56:28];
                sbr_pkg::OP_P4: w_next = (r_val < 0) ? 29'd0 : r_val[28:0];
                sbr_pkg::OP_COEF: begin
                    coeff_next[cmd.k] = neg_reg ? $signed(mag) : -$signed(mag);
                end
                sbr_pkg::OP_XMUL: begin
                    x_next   = shr16[31:0];
                    sum_next = '0;
                end
                sbr_pkg::OP_SDECAY: level_next = prod_reg[47:16];
                sbr_pkg::OP_BR: acc_next = shr16[35:0];
                sbr_pkg::OP_CP: acc_next = acc_reg - shr22[35:0];
                sbr_pkg::OP_RP: begin
                    p2_next[cmd.k] = p1_reg[cmd.k];
                    p1_next[cmd.k] = y_sat;
                    sum_next       = sum_reg + 35'(y_sat);
                end
                default: ;
            endcase
        end
        // Differencing filter and output saturation.
        if (cmd.load_out) begin
            sd1_next = sd0_reg;
            sd0_next = s_sat;
            if (diff > sbr_pkg::OUT_MAX)      out_next = sbr_pkg::OUT_MAX[sbr_pkg::OUT_WIDTH-1:0];
            else if (diff < sbr_pkg::OUT_MIN) out_next = sbr_pkg::OUT_MIN[sbr_pkg::OUT_WIDTH-1:0];
            else                              out_next = diff[sbr_pkg::OUT_WIDTH-1:0];
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_reg <= '0;
            level_reg  <= '0;
            prng_reg   <= sbr_pkg::PRNG_SEED;
            sd0_reg    <= '0;
            sd1_reg    <= '0;
            outv_reg   <= 1'b0;
            for (int i = 0; i < sbr_pkg::NUM_RES; i++) begin
                p1_reg[i] <= '0;
                p2_reg[i] <= '0;
            end
        end else begin
            energy_reg <= energy_next;
            level_reg  <= level_next;
            prng_reg   <= prng_next;
            sd0_reg    <= sd0_next;
            sd1_reg    <= sd1_next;
            outv_reg   <= cmd.load_out | (outv_reg & ~m_tready);
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
        end
    end

    // Working registers without reset.
    always_ff @(posedge aclk) begin
        if (cmd.take) shake_reg <= shake_in;
        draw_reg  <= draw_next;
        jp_reg    <= jp_next;
        t_reg     <= t_next;
        neg_reg   <= neg_next;
        u2_reg    <= u2_next;
        w_reg     <= w_next;
        x_reg     <= x_next;
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        coeff_reg <= coeff_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = outv_reg;
    assign m_tdata  = sbr_pkg::TDATA_W'(out_reg);

endmodule

### src/stochastic_bell_resonator_synth_unit.sv
// One shared multiplier; a tick with a bell event also recomputes the resonator coefficients.
// Each datapath operation is a multiply followed by a write-back; requests are taken one
// at a time, each once the previous result sits in the output register.
// Reset (synchronous, aresetn low) restores the configuration and state, then a pass
// computes the five resonator coefficients before s_tready rises.
// Configuration writes are taken on any cycle.
module stochastic_bell_resonator_synth_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] shake_amount
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [sbr_pkg::TDATA_W-1:0] m_tdata, // [23:0] sample_out
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_wr_data
);

    sbr_pkg::cmd_t    cmd;
    sbr_pkg::status_t status;

    // Sequencer.
    sbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    sbr_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .shake_in    (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for the stochastic bell resonator synthesiser unit.
`timescale 1ns / 1ps

module tb;

    localparam logic [3:0] CFG_SPARE = 4'd15;  // index with no register behind it
    localparam logic [3:0] REG_ORDER [8] = '{sbr_pkg::CFG_THRESHOLD, sbr_pkg::CFG_GAIN,
        sbr_pkg::CFG_DECAY, sbr_pkg::CFG_STEP0, sbr_pkg::CFG_STEP1, sbr_pkg::CFG_STEP2,
        sbr_pkg::CFG_STEP3, sbr_pkg::CFG_STEP4};
    localparam int PHASE_ITEMS = 320;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [15:0]                  s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [sbr_pkg::TDATA_W-1:0]  m_tdata;
    logic                         cfg_wr_en = 1'b0;
    logic [3:0]                   cfg_index = '0;
    logic [15:0]                  cfg_wr_data = '0;

    stochastic_bell_resonator_synth_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // Predictor copy of the registers and the synthesis state.
    logic [10:0] bell_count;
    logic [15:0] strike_gain, energy_fade;
    logic [14:0] centre_step [sbr_pkg::NUM_RES];
    logic [31:0] energy, level, lcg;
    int          coeff [sbr_pkg::NUM_RES];
    int          out_d1 [sbr_pkg::NUM_RES];
    int          out_d2 [sbr_pkg::NUM_RES];
    int          mix_d1, mix_d2;

    logic [sbr_pkg::OUT_WIDTH-1:0] pending_samples [$];
    int errors = 0;
    bit no_sink_idle = 1'b0;
    bit no_source_idle = 1'b0;

    typedef struct {
        logic [15:0]                   shake;
        bit                            fixed;
        logic [sbr_pkg::OUT_WIDTH-1:0] sample;
    } shake_row_t;

    function automatic int clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic logic [14:0] next_draw();
        lcg = lcg * 32'd1103515245 + 32'd12345;
        return lcg[30:16];
    endfunction

    // Polynomial cosine in Q28 of a phase truncated to the table grid.
    function automatic longint cosine_q28(input logic [15:0] ph);
        longint unsigned t, u2, w;
        longint r;
        bit neg;
        neg = 1'b0;
        t = longint'((ph >> sbr_pkg::PH_SHIFT) << sbr_pkg::PH_SHIFT);
        if (t >= 32768) t = 65536 - t;
        if (t > 16384) begin
            neg = 1'b1;
            t = 32768 - t;
        end
        u2 = t * t;
        w = (sbr_pkg::POLY_D * u2) >> 28;
        w = ((sbr_pkg::POLY_C - w) * u2) >> 28;
        w = ((sbr_pkg::POLY_B - w) * u2) >> 28;
        w = ((sbr_pkg::POLY_A - w) * u2) >> 28;
        r = (64'sd1 << 28) - longint'(w);
        if (r < 0) r = 0;
        return neg ? -r : r;
    endfunction

    function automatic int pole_coeff(input logic [15:0] ph);
        longint c, mag;
        c = cosine_q28(ph);
        mag = ((c < 0 ? -c : c) * longint'(sbr_pkg::TWO_R_Q16)) >>> 22;
        return (c >= 0) ? -int'(mag) : int'(mag);
    endfunction

    function automatic void bell_reset();
        bell_count  = 11'd32;
        strike_gain = 16'd1024;
        energy_fade = 16'd65497;
        centre_step = '{15'd3715, 15'd7876, 15'd9660, 15'd12334, 15'd14564};
        energy = '0;
        level  = '0;
        lcg    = 32'd12345;
        for (int k = 0; k < sbr_pkg::NUM_RES; k++) begin
            coeff[k]  = pole_coeff({1'b0, centre_step[k]});
            out_d1[k] = 0;
            out_d2[k] = 0;
        end
        mix_d1 = 0;
        mix_d2 = 0;
    endfunction

    function automatic void bell_write(input logic [3:0] idx, input logic [15:0] v);
        case (idx)
            sbr_pkg::CFG_THRESHOLD: bell_count  = v[10:0];
            sbr_pkg::CFG_GAIN:      strike_gain = v;
            sbr_pkg::CFG_DECAY:     energy_fade = v;
            sbr_pkg::CFG_STEP0:     centre_step[0] = v[14:0];
            sbr_pkg::CFG_STEP1:     centre_step[1] = v[14:0];
            sbr_pkg::CFG_STEP2:     centre_step[2] = v[14:0];
            sbr_pkg::CFG_STEP3:     centre_step[3] = v[14:0];
            sbr_pkg::CFG_STEP4:     centre_step[4] = v[14:0];
            default: ;
        endcase
    endfunction

    // One audio tick: returns the output sample that the tick produces.
    function automatic logic [sbr_pkg::OUT_WIDTH-1:0] bell_tick(input logic [15:0] shake);
        longint unsigned e, sl;
        longint x, y, mix, jit, n, data, lim;
        logic [14:0] d;
        logic [15:0] ph;
        if (shake != 0) begin
            e = longint'(energy) + ((longint'(shake) * sbr_pkg::TENTH_Q16 + 512) >> 10);
            energy = (e > sbr_pkg::ENERGY_ONE) ? 32'(sbr_pkg::ENERGY_ONE) : e[31:0];
        end
        e = (longint'(energy) * energy_fade) >> 16;
        energy = e[31:0];

        d = next_draw();
        if ({6'd0, d[14:5]} < {5'd0, bell_count}) begin
            sl = longint'(level) + ((longint'(strike_gain) * energy) >> 12);
            level = (sl > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sl[31:0];
            for (int k = 0; k < sbr_pkg::NUM_RES; k++) begin
                n = longint'(next_draw()) - 16384;
                jit = (longint'(centre_step[k]) * n *
                       longint'(sbr_pkg::jit_gain(k[2:0]))) >>> 30;
                ph = 16'(longint'(centre_step[k]) + jit);
                coeff[k] = pole_coeff(ph);
            end
        end

        x = (longint'(level) * (longint'(next_draw()) - 16384)) >>> 16;
        sl = (longint'(level) * sbr_pkg::SOUND_DECAY_Q16) >> 16;
        level = sl[31:0];

        mix = 0;
        for (int k = 0; k < sbr_pkg::NUM_RES; k++) begin
            y = (x * longint'(sbr_pkg::branch_gain(k[2:0]))) >>> 16;
            y -= (longint'(coeff[k]) * longint'(out_d1[k])) >>> 22;
            y -= (longint'(sbr_pkg::R_SQ_Q22) * longint'(out_d2[k])) >>> 22;
            out_d2[k] = out_d1[k];
            out_d1[k] = clip32(y);
            mix += out_d1[k];
        end

        data = longint'(mix_d2) - longint'(clip32(mix));
        mix_d2 = mix_d1;
        mix_d1 = clip32(mix);
        lim = 64'sd1 << (sbr_pkg::OUT_WIDTH - 1);
        if (data > lim - 1) data = lim - 1;
        if (data < -lim) data = -lim;
        return data[sbr_pkg::OUT_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input logic [sbr_pkg::OUT_WIDTH-1:0] got,
                                   input logic [sbr_pkg::OUT_WIDTH-1:0] want);
        errors++;
        $display("sample_out mismatch at %0t: got %0d, expected %0d",
                 $realtime, $signed(got), $signed(want));
    endtask

    // Program all registers plus the spare index, only while the block is idle.
    task automatic program_regs(input logic [15:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= REG_ORDER[i];
            cfg_wr_data <= vals[i];
            @(posedge aclk);
            bell_write(REG_ORDER[i], vals[i]);
        end
        cfg_index   <= CFG_SPARE;
        cfg_wr_data <= 16'hFFFF;
        @(posedge aclk);
        bell_write(CFG_SPARE, 16'hFFFF);
        cfg_wr_en <= 1'b0;
    endtask

    // Issue one request; the valid is held between back-to-back requests.
    task automatic send_shake(input logic [15:0] shake, input bit fixed,
                              input logic [sbr_pkg::OUT_WIDTH-1:0] sample);
        int gap;
        logic [sbr_pkg::OUT_WIDTH-1:0] want;
        gap = no_source_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= shake;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = bell_tick(shake);
        pending_samples.push_back(fixed ? sample : want);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_shake();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'd0;
            4:          return 16'hFFFF;
            5:          return 16'(1 << $urandom_range(0, 15));
            default:    return 16'($urandom);
        endcase
    endfunction

    // Result side: random back-pressure, checked against the oldest expectation.
    initial begin
        int gap;
        logic [sbr_pkg::OUT_WIDTH-1:0] want;
        forever begin
            gap = no_sink_idle ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_samples.size() == 0) begin
                errors++;
                $display("unexpected sample_out %0d at %0t",
                         $signed(m_tdata[sbr_pkg::OUT_WIDTH-1:0]), $realtime);
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata[sbr_pkg::OUT_WIDTH-1:0] !== want)
                    report_mismatch(m_tdata[sbr_pkg::OUT_WIDTH-1:0], want);
            end
        end
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("stochastic_bell_resonator_synth_unit verification failed");
        $finish;
    end

    // Main sequence.
    initial begin
        shake_row_t rows [20];
        logic [15:0] regs [8];
        bell_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests: silence straight after reset, then shake extremes, bit patterns and silence.
        rows = '{
            '{16'd0, 1'b1, '0}, '{16'd0, 1'b1, '0}, '{16'hFFFF, 1'b0, '0},
            '{16'hFFFF, 1'b0, '0}, '{16'd1, 1'b0, '0}, '{16'h8000, 1'b0, '0},
            '{16'h5555, 1'b0, '0}, '{16'hAAAA, 1'b0, '0}, '{16'd0, 1'b0, '0},
            '{16'hFFFF, 1'b0, '0}, '{16'hFFFF, 1'b0, '0}, '{16'hFFFF, 1'b0, '0},
            '{16'h00FF, 1'b0, '0}, '{16'hFF00, 1'b0, '0}, '{16'd0, 1'b0, '0},
            '{16'd0, 1'b0, '0}, '{16'd0, 1'b0, '0}, '{16'h7FFF, 1'b0, '0},
            '{16'hFFFF, 1'b0, '0}, '{16'd0, 1'b0, '0}
        };
        foreach (rows[i]) send_shake(rows[i].shake, rows[i].fixed, rows[i].sample);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: regs = '{16'd1024, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF};
                // Threshold above the draw range: every tick strikes.
                1: regs = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0,
                            16'd0, 16'd0};
                // No bell can ever strike.
                2: regs = '{16'd0, 16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
                3: regs = '{16'd1, 16'd4096, 16'd60000, 16'd1, 16'd2, 16'd3,
                            16'd100, 16'd20000};
                // Loud and dense, to drive the resonators and the output into saturation.
                4: regs = '{16'd2047, 16'hFFFF, 16'd65000, 16'd3715, 16'd7876,
                            16'd9660, 16'd12334, 16'd14564};
                default: regs = '{16'($urandom_range(1, 1024)), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom)};
            endcase
            program_regs(regs);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 80 == 0) begin
                    no_source_idle = ($urandom_range(0, 3) == 0);
                    no_sink_idle   = ($urandom_range(0, 3) == 0);
                end
                send_shake(rand_shake(), 1'b0, '0);
            end
            drain();
        end

        if (errors == 0) begin
            $display("stochastic_bell_resonator_synth_unit verification clean");
        end else begin
            $display("stochastic_bell_resonator_synth_unit verification failed");
        end
        $finish;
    end

endmodule
